[rtl/core/preemptive_priority_round_robin_macros.svh]
// Assertion macros for the scheduler checker.
`ifndef PREEMPTIVE_PRIORITY_ROUND_ROBIN_MACROS_SVH
`define PREEMPTIVE_PRIORITY_ROUND_ROBIN_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define PPRR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define PPRR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

[rtl/core/pprr_pkg.sv]
// Package for the priority round robin scheduler: widths, defaults and opcodes.
package pprr_pkg;
  localparam int unsigned TaskSlotsDef = 16;
  localparam int unsigned PrioLevelsDef = 16;
  localparam int unsigned SlotFieldW = 4;
  localparam int unsigned PrioFieldW = 4;
  localparam int unsigned BurstW = 16;
  localparam int unsigned QuantW = 8;
  localparam int unsigned TimeW = 32;
  localparam logic [QuantW-1:0] QuantRst = 8'd4;
  localparam logic OpArrive = 1'b0;
  localparam logic OpTick = 1'b1;
endpackage

[rtl/core/preemptive_priority_round_robin.sv]
// Top level of the preemptive priority scheduler with round robin per level.
//  channel | dir | handshake              | payload
//  s_axis  | in  | s_axis_tvalid/tready   | tdata: slot, prio, burst; tuser: opcode
//  m_axis  | out | m_axis_tvalid/tready   | tdata: result fields
//  cfg     | in  | cfg_valid_i/cfg_ready_o| quantum_length
// An arrival writes the slot and pushes it onto its level's queue; an ignored arrival
// is dropped in idle. A tick scans one level per cycle, then checks preemption,
// dispatches, runs and closes, with a push back when the quantum expires; a preemption
// adds a push and a second scan.
// Reset clears the queue flags, slot flags, CPU state and tick counter at once.
// A waiting result stalls only the run step of the next tick; arrivals pass meanwhile.
module preemptive_priority_round_robin
  import pprr_pkg::*;
#(
  parameter int unsigned TASK_SLOTS = TaskSlotsDef,
  parameter int unsigned PRIORITY_LEVELS = PrioLevelsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: task_slot[3:0], task_priority[7:4], burst_length[23:8]
  input  logic [23:0] s_axis_tdata,
  // tuser: opcode[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: busy_res[0], run_slot[4:1], run_priority[8:5], finished[9],
  // quantum_expired[10], preempted[11], time_now[43:12], zero[47:44]
  output logic [47:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);
  localparam int unsigned SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int unsigned LW = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
  localparam logic [LW-1:0] LvMax = LW'(PRIORITY_LEVELS - 1);

  typedef enum logic [2:0] {
    StIdle, StArrive, StScan, StPre, StDisp, StRun, StPush, StOut
  } state_e;

  state_e state_q;
  logic [QuantW-1:0] quant_q;
  logic [SW-1:0] nxt_q [TASK_SLOTS];
  logic [SW-1:0] head_q [PRIORITY_LEVELS];
  logic [SW-1:0] tail_q [PRIORITY_LEVELS];
  logic [BurstW-1:0] work_q [TASK_SLOTS];
  logic [LW-1:0] lvl_q [TASK_SLOTS];
  logic [PRIORITY_LEVELS-1:0] ne_q;
  logic [TASK_SLOTS-1:0] used_q;
  logic busy_q;
  logic [SW-1:0] cur_q;
  logic [QuantW-1:0] slice_q;
  logic [TimeW-1:0] tick_q;
  // scan state: level counter, found flag, found level; second pass flag
  logic [LW-1:0] scan_q, top_q;
  logic found_q, pass2_q, pre_q;
  logic [SW-1:0] push_q;
  logic [SW-1:0] in_slot_q;
  logic [LW-1:0] in_lvl_q;
  logic [BurstW-1:0] in_burst_q;
  logic out_v_q;
  logic [47:0] out_q;

  logic [SW-1:0] in_slot;
  logic [LW-1:0] in_lvl;
  logic slot_ok;
  logic [LW-1:0] plv;
  logic [BurstW-1:0] wnext;
  logic [QuantW-1:0] snext;
  logic out_free;
  logic run_go;

  always_comb begin
    slot_ok = (s_axis_tdata[3:0] < 4'(TASK_SLOTS)) || (TASK_SLOTS >= 16);
    in_slot = SW'(s_axis_tdata[3:0]);
    if (s_axis_tdata[7:4] >= 4'(PRIORITY_LEVELS - 1) && PRIORITY_LEVELS <= 16) begin
      in_lvl = LvMax;
    end else begin
      in_lvl = LW'(s_axis_tdata[7:4]);
    end
    plv = lvl_q[push_q];
    wnext = work_q[cur_q] - 1'b1;
    snext = slice_q - 1'b1;
  end

  // the run step may only fire once the output register is free
  assign out_free = !out_v_q || m_axis_tready;
  assign run_go = (state_q == StRun) && out_free;

  assign s_axis_tready = (state_q == StIdle);
  assign cfg_ready_o = 1'b1;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata = out_q;

  always_ff @(posedge clk_i) begin
    case (state_q)
      StArrive: begin
        lvl_q[in_slot_q] <= in_lvl_q;
        work_q[in_slot_q] <= in_burst_q;
      end
      StRun: begin
        if (out_free) begin
          work_q[cur_q] <= wnext;
        end
      end
      default: ;
    endcase
    if (state_q == StPush) begin
      if (ne_q[plv]) begin
        nxt_q[tail_q[plv]] <= push_q;
      end else begin
        head_q[plv] <= push_q;
      end
      tail_q[plv] <= push_q;
    end
    if (state_q == StDisp && found_q && !busy_q && head_q[top_q] != tail_q[top_q]) begin
      head_q[top_q] <= nxt_q[head_q[top_q]];
    end
    if (run_go) begin
      out_q <= {4'd0, tick_q, pre_q,
                busy_q && wnext != '0 && snext == '0,
                busy_q && wnext == '0,
                busy_q ? 4'(lvl_q[cur_q]) : 4'd0,
                busy_q ? 4'(cur_q) : 4'd0,
                busy_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      quant_q <= QuantRst;
      ne_q <= '0;
      used_q <= '0;
      busy_q <= 1'b0;
      cur_q <= '0;
      slice_q <= '0;
      tick_q <= '0;
      scan_q <= '0;
      top_q <= '0;
      found_q <= 1'b0;
      pass2_q <= 1'b0;
      pre_q <= 1'b0;
      push_q <= '0;
      in_slot_q <= '0;
      in_lvl_q <= '0;
      in_burst_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        quant_q <= cfg_data_i;
      end
      if (run_go) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (s_axis_tvalid && s_axis_tready) begin
            if (s_axis_tuser == OpTick) begin
              pre_q <= 1'b0;
              pass2_q <= 1'b0;
              scan_q <= LvMax;
              found_q <= 1'b0;
              state_q <= StScan;
            end else if (slot_ok && s_axis_tdata[23:8] != '0 && !used_q[in_slot]) begin
              in_slot_q <= in_slot;
              in_lvl_q <= in_lvl;
              in_burst_q <= s_axis_tdata[23:8];
              state_q <= StArrive;
            end
          end
        end
        StArrive: begin
          used_q[in_slot_q] <= 1'b1;
          push_q <= in_slot_q;
          pass2_q <= 1'b1;
          state_q <= StPush;
        end
        StScan: begin
          // walk down from the top level, keep the first nonempty one
          if (!found_q && ne_q[scan_q]) begin
            found_q <= 1'b1;
            top_q <= scan_q;
          end
          if (scan_q == '0) begin
            state_q <= pass2_q ? StDisp : StPre;
          end else begin
            scan_q <= scan_q - 1'b1;
          end
        end
        StPre: begin
          if (busy_q && found_q && top_q > lvl_q[cur_q]) begin
            busy_q <= 1'b0;
            pre_q <= 1'b1;
            push_q <= cur_q;
            state_q <= StPush;
          end else begin
            state_q <= StDisp;
          end
        end
        StPush: begin
          ne_q[plv] <= 1'b1;
          if (pass2_q) begin
            state_q <= StOut;
          end else begin
            pass2_q <= 1'b1;
            scan_q <= LvMax;
            found_q <= 1'b0;
            state_q <= StScan;
          end
        end
        StDisp: begin
          if (!busy_q && found_q) begin
            cur_q <= head_q[top_q];
            slice_q <= (quant_q == '0) ? QuantW'(1) : quant_q;
            busy_q <= 1'b1;
            if (head_q[top_q] == tail_q[top_q]) begin
              ne_q[top_q] <= 1'b0;
            end
          end
          state_q <= StRun;
        end
        StRun: begin
          // hold here while the previous result still waits
          if (out_free) begin
            tick_q <= tick_q + 1'b1;
            if (busy_q) begin
              slice_q <= snext;
              if (wnext == '0) begin
                used_q[cur_q] <= 1'b0;
                busy_q <= 1'b0;
                state_q <= StOut;
              end else if (snext == '0) begin
                busy_q <= 1'b0;
                push_q <= cur_q;
                pass2_q <= 1'b1;
                state_q <= StPush;
              end else begin
                state_q <= StOut;
              end
            end else begin
              state_q <= StOut;
            end
          end
        end
        StOut: state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule

[rtl/core/pprr_checker.sv]
// Port-level checker for the scheduler, bound to the top level.
`include "preemptive_priority_round_robin_macros.svh"
module pprr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);
  `PPRR_ASSERT_IMP(a_idle_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[11:1] == '0, "idle tick with fields set")
  `PPRR_ASSERT_IMP(a_one_outcome, clk_i, rst_ni, m_axis_tvalid, !(m_axis_tdata[9] && m_axis_tdata[10]), "finish and expiry together")
  `PPRR_ASSERT_NXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped while stalled")
  `PPRR_ASSERT_IMP(a_pad_zero, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[47:44] == '0, "pad bits set")
endmodule

bind preemptive_priority_round_robin pprr_checker u_pprr_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
